// ===== hdl/qdec_pkg.sv =====
// shared types, step table and codes for the quadrature decoder with tap
package qdec_pkg;

    localparam int EVENT_DATA_BITS  = 40;
    localparam int RESULT_DATA_BITS = 40;
    localparam int CFG_INDEX_BITS   = 8;
    localparam int CFG_DATA_BITS    = 16;
    localparam int TIME_BITS        = 32;
    localparam int OUT_POS_BITS     = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_CROSSTALK = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DEBOUNCE  = 8'd1;

    localparam logic [7:0]  CROSSTALK_RESET = 8'd10;
    localparam logic [15:0] DEBOUNCE_RESET  = 16'd200;

    localparam logic CMD_ROTARY = 1'b0;
    localparam logic CMD_SWITCH = 1'b1;

    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_CW   = 2'b01;
    localparam logic [1:0] DIR_CCW  = 2'b10;

    localparam logic [1:0] STEP_NONE = 2'b00;
    localparam logic [1:0] STEP_CW   = 2'b01;
    localparam logic [1:0] STEP_CCW  = 2'b11;

    typedef struct packed {
        logic                 command;
        logic                 pin_a;
        logic                 pin_b;
        logic                 switch_level;
        logic [TIME_BITS-1:0] now_ms;
    } event_t;

    typedef struct packed {
        logic [1:0] dir;
        logic [2:0] next_state;
    } table_entry_t;

    // rows: decoder state, columns: {pin_a, pin_b}
    localparam table_entry_t STEP_TABLE [0:7][0:3] = '{
        '{'{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd1}, '{DIR_CW,   3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd3}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd1}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd6}, '{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd6}, '{DIR_NONE, 3'd5}, '{DIR_NONE, 3'd0}, '{DIR_CCW,  3'd0}},
        '{'{DIR_NONE, 3'd6}, '{DIR_NONE, 3'd5}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}},
        '{'{DIR_NONE, 3'd0}, '{DIR_NONE, 3'd2}, '{DIR_NONE, 3'd4}, '{DIR_NONE, 3'd0}}
    };

endpackage

// ===== hdl/qdec_rotary.sv =====
// full-step table decoder and wrapping position counter
module qdec_rotary
    import qdec_pkg::*;
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  event_t                  ev,
    output logic [OUT_POS_BITS-1:0] position,
    output logic [1:0]              step,
    output logic [TIME_BITS-1:0]    last_edge_time
);

    logic [2:0]               state_reg, state_next;
    logic [1:0]               pins_reg, pins_next;
    logic                     pins_valid_reg, pins_valid_next;
    logic [POSITION_BITS-1:0] count_reg, count_next;
    logic [TIME_BITS-1:0]     edge_time_reg, edge_time_next;

    logic         decode;
    logic [1:0]   pins;
    table_entry_t entry;

    assign pins  = {ev.pin_a, ev.pin_b};
    assign entry = STEP_TABLE[state_reg][pins];

    assign decode = (ev.command == CMD_ROTARY) && ev.switch_level
                    && !(pins_valid_reg && (pins == pins_reg));

    always_comb
    begin
        state_next      = state_reg;
        pins_next       = pins_reg;
        pins_valid_next = pins_valid_reg;
        count_next      = count_reg;
        edge_time_next  = edge_time_reg;
        step            = STEP_NONE;
        if (decode)
        begin
            state_next      = entry.next_state;
            pins_next       = pins;
            pins_valid_next = 1'b1;
            edge_time_next  = ev.now_ms;
            case (entry.dir)
                DIR_CW:
                begin
                    count_next = count_reg + 1'b1;
                    step       = STEP_CW;
                end
                DIR_CCW:
                begin
                    count_next = count_reg - 1'b1;
                    step       = STEP_CCW;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign position       = OUT_POS_BITS'($signed(count_next));
    assign last_edge_time = edge_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= 3'd0;
            pins_reg       <= 2'd0;
            pins_valid_reg <= 1'b0;
            count_reg      <= '0;
            edge_time_reg  <= '0;
        end
        else if (fire)
        begin
            state_reg      <= state_next;
            pins_reg       <= pins_next;
            pins_valid_reg <= pins_valid_next;
            count_reg      <= count_next;
            edge_time_reg  <= edge_time_next;
        end
    end

endmodule

// ===== hdl/qdec_tap.sv =====
// switch tap qualification against crosstalk and debounce windows
module qdec_tap
    import qdec_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  event_t               ev,
    input  logic [TIME_BITS-1:0] last_edge_time,
    input  logic [7:0]           crosstalk_window_ms,
    input  logic [15:0]          debounce_window_ms,
    output logic                 tap
);

    logic [TIME_BITS-1:0] tap_time_reg, tap_time_next;
    logic [TIME_BITS-1:0] since_edge;
    logic [TIME_BITS-1:0] since_tap;

    assign since_edge = ev.now_ms - last_edge_time;
    assign since_tap  = ev.now_ms - tap_time_reg;

    assign tap = (ev.command == CMD_SWITCH)
                 && (since_edge >= TIME_BITS'(crosstalk_window_ms))
                 && (since_tap >= TIME_BITS'(debounce_window_ms));

    assign tap_time_next = tap ? ev.now_ms : tap_time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_time_reg <= '0;
        end
        else if (fire)
        begin
            tap_time_reg <= tap_time_next;
        end
    end

endmodule

// ===== hdl/quadrature_decoder_with_tap_core.sv =====
// top level: input register, decode and tap logic, result register, config registers
// result path: an event passes through the input register and then the result register
// throughput: one event per cycle while the output side accepts; the state update and output register set the pace
// the input register holds one more event while a result waits for the output side
// reset (rst_n, asynchronous, active low) clears decoder state, times, position
// and loads the crosstalk window with 10 and the debounce window with 200
module quadrature_decoder_with_tap_core
    import qdec_pkg::*;
#(
    parameter int POSITION_BITS = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // pin_a, pin_b, switch_level, now_ms[31:0], zero pad
    input  logic [EVENT_DATA_BITS-1:0]  s_axis_tdata,
    // command
    input  logic                        s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // position[31:0], step[1:0], tap, zero pad
    output logic [RESULT_DATA_BITS-1:0] m_axis_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [CFG_DATA_BITS-1:0]    cfg_data
);

    event_t                      ev_reg, ev_next;
    logic                        in_valid_reg, in_valid_next;
    logic [RESULT_DATA_BITS-1:0] out_data_reg, out_data_next;
    logic                        out_valid_reg, out_valid_next;
    logic [7:0]                  crosstalk_reg;
    logic [15:0]                 debounce_reg;

    logic                        fire;
    logic                        in_take;
    logic [OUT_POS_BITS-1:0]     position;
    logic [1:0]                  step;
    logic                        tap;
    logic [TIME_BITS-1:0]        last_edge_time;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_comb
    begin
        ev_next.command      = s_axis_tuser;
        ev_next.pin_a        = s_axis_tdata[0];
        ev_next.pin_b        = s_axis_tdata[1];
        ev_next.switch_level = s_axis_tdata[2];
        ev_next.now_ms       = s_axis_tdata[34:3];
    end

    assign in_valid_next  = in_take || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !m_axis_tready);
    assign out_data_next  = {5'd0, tap, step, position};

    qdec_rotary #(
        .POSITION_BITS (POSITION_BITS)
    ) u_rotary (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .ev             (ev_reg),
        .position       (position),
        .step           (step),
        .last_edge_time (last_edge_time)
    );

    qdec_tap u_tap (
        .clk                 (clk),
        .rst_n               (rst_n),
        .fire                (fire),
        .ev                  (ev_reg),
        .last_edge_time      (last_edge_time),
        .crosstalk_window_ms (crosstalk_reg),
        .debounce_window_ms  (debounce_reg),
        .tap                 (tap)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_reg <= ev_next;
        end
        if (fire)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crosstalk_reg <= CROSSTALK_RESET;
            debounce_reg  <= DEBOUNCE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CROSSTALK: crosstalk_reg <= cfg_data[7:0];
                CFG_DEBOUNCE:  debounce_reg  <= cfg_data;
                default:       crosstalk_reg <= crosstalk_reg;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== tb/quadrature_decoder_with_tap_core_test.sv =====
// testbench for the quadrature decoder with tap: directed and random pin events
module quadrature_decoder_with_tap_core_test;
    import qdec_pkg::*;

    localparam int LIMIT_CYCLES = 2000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 292;
    localparam int PRINT_CAP    = 100;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED     = CFG_DEBOUNCE + 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST_INDEX = 8'hFF;

    localparam logic [5:0] TURN_CW   = 6'h10;
    localparam logic [5:0] TURN_CCW  = 6'h20;
    localparam logic [5:0] TURN_MASK = 6'h30;

    // rows: decoder state, columns: {pin_a, pin_b}; low bits hold the next state
    localparam logic [5:0] DETENT_TABLE [0:7][0:3] = '{
        '{6'h00, 6'h02, 6'h04, 6'h00},
        '{6'h03, 6'h00, 6'h01, TURN_CW},
        '{6'h03, 6'h02, 6'h00, 6'h00},
        '{6'h03, 6'h02, 6'h01, 6'h00},
        '{6'h06, 6'h00, 6'h04, 6'h00},
        '{6'h06, 6'h05, 6'h00, TURN_CCW},
        '{6'h06, 6'h05, 6'h04, 6'h00},
        '{6'h00, 6'h02, 6'h04, 6'h00}
    };

    // pin pairs of one detent, clockwise order
    localparam logic [1:0] DETENT_PINS [0:3] = '{2'b11, 2'b01, 2'b00, 2'b10};

    typedef struct packed {
        logic [OUT_POS_BITS-1:0] position;
        logic [1:0]              step;
        logic                    tap;
    } outcome_t;

    typedef struct packed {
        event_t   ev;
        logic     typed;
        outcome_t want;
    } stim_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [EVENT_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic                        s_axis_tuser = 1'b0;
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [RESULT_DATA_BITS-1:0] m_axis_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]    cfg_data = '0;

    // decoder copy
    logic [2:0]              dec_state = 3'd0;
    logic [1:0]              prev_pins = 2'b00;
    logic                    pins_seen = 1'b0;
    logic [OUT_POS_BITS-1:0] turn_count = '0;
    logic [TIME_BITS-1:0]    edge_ms = '0;
    logic [TIME_BITS-1:0]    tap_ms = '0;
    logic [7:0]              xtalk_ms = CROSSTALK_RESET;
    logic [15:0]             debounce_ms = DEBOUNCE_RESET;

    outcome_t  pending_results[$];
    stim_row_t directed_plan[$];

    // knob model for the random part
    logic [1:0]           knob_phase = 2'd0;
    bit                   turning_cw = 1'b1;
    logic [TIME_BITS-1:0] clock_ms = 32'h0000_0040;

    bit quiet = 1'b0;
    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int mismatches = 0;
    int stall_cycles = 0;

    quadrature_decoder_with_tap_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic outcome_t decode_event(input event_t ev);
        outcome_t             res;
        logic [1:0]           pins;
        logic [5:0]           entry;
        logic [TIME_BITS-1:0] since_edge;
        logic [TIME_BITS-1:0] since_tap;
        res.step = STEP_NONE;
        res.tap = 1'b0;
        if (ev.command == CMD_ROTARY)
        begin
            pins = {ev.pin_a, ev.pin_b};
            if (ev.switch_level && !(pins_seen && pins == prev_pins))
            begin
                prev_pins = pins;
                pins_seen = 1'b1;
                edge_ms = ev.now_ms;
                entry = DETENT_TABLE[dec_state][pins];
                dec_state = entry[2:0];
                if ((entry & TURN_MASK) == TURN_CW)
                begin
                    turn_count = turn_count + 1'b1;
                    res.step = STEP_CW;
                end
                else if ((entry & TURN_MASK) == TURN_CCW)
                begin
                    turn_count = turn_count - 1'b1;
                    res.step = STEP_CCW;
                end
            end
        end
        else
        begin
            since_edge = ev.now_ms - edge_ms;
            since_tap = ev.now_ms - tap_ms;
            if (since_edge >= {24'd0, xtalk_ms} && since_tap >= {16'd0, debounce_ms})
            begin
                tap_ms = ev.now_ms;
                res.tap = 1'b1;
            end
        end
        res.position = turn_count;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches = mismatches + 1;
        if (mismatches <= PRINT_CAP)
            $display("mismatch: %s got %h expected %h", what, got, want);
    endtask

    task automatic add_row(input logic cmd, input logic a, input logic b, input logic sw,
                           input logic [31:0] now, input logic typed,
                           input logic [31:0] pos, input logic [1:0] step, input logic tap);
        stim_row_t row;
        row.ev.command = cmd;
        row.ev.pin_a = a;
        row.ev.pin_b = b;
        row.ev.switch_level = sw;
        row.ev.now_ms = now;
        row.typed = typed;
        row.want.position = pos;
        row.want.step = step;
        row.want.tap = tap;
        directed_plan.push_back(row);
    endtask

    task automatic send_event(input event_t ev, input logic typed, input outcome_t want);
        outcome_t pred;
        int       gap;
        if (!quiet && !calm && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= ev.command;
        s_axis_tdata <= {5'b0, ev.now_ms, ev.switch_level, ev.pin_b, ev.pin_a};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pred = decode_event(ev);
        pending_results.push_back(typed ? want : pred);
    endtask

    // valid is left high so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_CROSSTALK: xtalk_ms = val[7:0];
            CFG_DEBOUNCE:  debounce_ms = val;
            default: ;
        endcase
    endtask

    task automatic random_event(output event_t ev);
        int          pick;
        int          span;
        int unsigned delta;
        pick = $urandom_range(0, 99);
        span = $urandom_range(0, 99);
        if (span < 70)
            delta = $urandom_range(0, 40);
        else if (span < 90)
            delta = $urandom_range(0, 400);
        else if (span < 98)
            delta = $urandom_range(0, 100000);
        else
            delta = $urandom;
        clock_ms = clock_ms + delta;
        ev.now_ms = clock_ms;
        ev.command = CMD_ROTARY;
        ev.switch_level = 1'b1;
        if (pick < 65 || (pick >= 80 && pick < 85))
        begin
            if ($urandom_range(0, 9) == 0)
                turning_cw = !turning_cw;
            // contact bounce steps back once
            if (turning_cw ^ ($urandom_range(0, 11) == 0))
                knob_phase = knob_phase + 2'd1;
            else
                knob_phase = knob_phase - 2'd1;
            {ev.pin_a, ev.pin_b} = DETENT_PINS[knob_phase];
            if (pick >= 80)
                ev.switch_level = 1'b0;
        end
        else if (pick < 75)
        begin
            {ev.pin_a, ev.pin_b, ev.switch_level} = 3'($urandom_range(0, 7));
        end
        else if (pick < 80)
        begin
            {ev.pin_a, ev.pin_b} = DETENT_PINS[knob_phase];
        end
        else
        begin
            ev.command = CMD_SWITCH;
            {ev.pin_a, ev.pin_b, ev.switch_level} = 3'($urandom_range(0, 7));
        end
    endtask

    // result side
    initial
    begin : sink
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && !calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", m_axis_tdata[31:0], 32'h0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.position)
                    report_mismatch("position", m_axis_tdata[31:0], want.position);
                if (m_axis_tdata[33:32] !== want.step)
                    report_mismatch("step", {30'd0, m_axis_tdata[33:32]}, {30'd0, want.step});
                if (m_axis_tdata[34] !== want.tap)
                    report_mismatch("tap", {31'd0, m_axis_tdata[34]}, {31'd0, want.tap});
            end
        end
    end

    // longest legal quiet stretch is the receiver hold-off plus one idle burst
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : main_flow
        int                       ph;
        int                       n;
        event_t                   ev;
        outcome_t                 none;
        stim_row_t                row;
        logic [CFG_DATA_BITS-1:0] cfg_word;
        none = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // switch edges against reset times and windows
        add_row(CMD_SWITCH, 1'b0, 1'b0, 1'b1, 32'd0,   1'b1, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_SWITCH, 1'b1, 1'b1, 1'b0, 32'd5,   1'b1, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_SWITCH, 1'b0, 1'b1, 1'b1, 32'd199, 1'b1, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_SWITCH, 1'b1, 1'b0, 1'b0, 32'd200, 1'b1, 32'h0, STEP_NONE, 1'b1);
        // pressed switch, then first decode after reset, then repeated pins
        add_row(CMD_ROTARY, 1'b1, 1'b1, 1'b0, 32'd300, 1'b1, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b0, 1'b1, 32'd400, 1'b1, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b0, 1'b1, 32'd401, 1'b1, 32'h0, STEP_NONE, 1'b0);
        // crosstalk after a rotary edge
        add_row(CMD_SWITCH, 1'b0, 1'b0, 1'b1, 32'd405, 1'b1, 32'h0, STEP_NONE, 1'b0);
        // one detent clockwise, two counter-clockwise
        add_row(CMD_ROTARY, 1'b1, 1'b1, 1'b1, 32'd500, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b1, 1'b1, 32'd501, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b0, 1'b1, 32'd502, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b1, 1'b0, 1'b1, 32'd503, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b1, 1'b1, 1'b1, 32'd504, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b1, 1'b0, 1'b1, 32'd505, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b0, 1'b1, 32'd506, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b1, 1'b1, 32'd507, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b1, 1'b1, 1'b1, 32'd508, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b1, 1'b0, 1'b1, 32'd509, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b0, 1'b1, 32'd510, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b1, 1'b1, 32'd511, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b1, 1'b1, 1'b1, 32'd512, 1'b1, 32'hFFFF_FFFF, STEP_CCW, 1'b0);
        // timestamp extremes and wrap of the debounce difference
        add_row(CMD_SWITCH, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                STEP_NONE, 1'b1);
        add_row(CMD_SWITCH, 1'b0, 1'b0, 1'b0, 32'h0000_0010, 1'b1, 32'hFFFF_FFFF,
                STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b1, 1'b1, 1'b1, 32'h0000_0020, 1'b0, 32'h0, STEP_NONE, 1'b0);
        add_row(CMD_ROTARY, 1'b0, 1'b1, 1'b0, 32'h0000_0030, 1'b0, 32'h0, STEP_NONE, 1'b0);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            send_event(row.ev, row.typed, row.want);
        end
        s_axis_tvalid <= 1'b0;

        for (ph = 0; ph < 6; ph++)
        begin
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            case (ph)
                0:
                begin
                    write_reg(CFG_CROSSTALK, 16'h0000);
                    write_reg(CFG_DEBOUNCE, 16'h0000);
                end
                1:
                begin
                    write_reg(CFG_CROSSTALK, 16'h00FF);
                    write_reg(CFG_DEBOUNCE, 16'hFFFF);
                end
                2:
                begin
                    cfg_word = 16'($urandom);
                    cfg_word[7:0] = 8'($urandom_range(1, 60));
                    write_reg(CFG_CROSSTALK, cfg_word);
                    write_reg(CFG_DEBOUNCE, 16'($urandom_range(1, 1000)));
                end
                3:
                begin
                    write_reg(CFG_UNUSED, 16'($urandom));
                    write_reg(CFG_LAST_INDEX, 16'($urandom));
                end
                4:
                begin
                    write_reg(CFG_DEBOUNCE, 16'd50);
                    write_reg(CFG_CROSSTALK, 16'hA503);
                end
                default:
                begin
                    write_reg(CFG_CROSSTALK, {8'd0, CROSSTALK_RESET});
                    write_reg(CFG_DEBOUNCE, DEBOUNCE_RESET);
                    quiet = 1'b1;
                end
            endcase
            cfg_valid <= 1'b0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 64 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (ph == 4 && n == 100)
                    hold_request = 1'b1;
                random_event(ev);
                send_event(ev, 1'b0, none);
            end
            s_axis_tvalid <= 1'b0;
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
